[rtl/dtlv_pkg.sv]
package dtlv_pkg;

	localparam int MAX_LEN_BYTES = 4;

	localparam int BYTE_W   = 8;
	localparam int LENGTH_W = 32;
	localparam int HDR_W    = 3;
	localparam int LEFT_W   = $clog2(MAX_LEN_BYTES + 1);

	localparam logic [7:0] LONG_FORM_BIT = 8'h80;
	localparam logic [7:0] COUNT_MASK    = 8'h7F;

	localparam logic [HDR_W-1:0] HDR_TAG_ONLY = HDR_W'(1);
	localparam logic [HDR_W-1:0] HDR_TAG_LEN  = HDR_W'(2);

	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_BAD_LEN = 1'b1;

	typedef enum logic [2:0] {
		PH_TAG  = 3'b001,
		PH_LEN  = 3'b010,
		PH_MORE = 3'b100
	} phase_t;

	typedef struct packed {
		logic [BYTE_W-1:0]   tag_value;
		logic [LENGTH_W-1:0] value_length;
		logic [HDR_W-1:0]    header_bytes;
		logic                status;
	} hdr_result_t;

endpackage

[rtl/dtlv_byte_if.sv]
interface dtlv_byte_if;
	logic                       valid;
	logic                       ready;
	logic [dtlv_pkg::BYTE_W-1:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

[rtl/dtlv_hdr_if.sv]
interface dtlv_hdr_if;
	logic                         valid;
	logic                         ready;
	logic [dtlv_pkg::BYTE_W-1:0]   tag_value;
	logic [dtlv_pkg::LENGTH_W-1:0] value_length;
	logic [dtlv_pkg::HDR_W-1:0]    header_bytes;
	logic                         status;

	modport source (output valid, output tag_value, output value_length,
		output header_bytes, output status, input ready);
	modport sink   (input valid, input tag_value, input value_length,
		input header_bytes, input status, output ready);
endinterface

[rtl/der_tlv_header_parser_unit.sv]
// DER TLV header parser: one header byte per transaction.
// Path: an accepted byte is held in the input stage, then parsed into the parser
// state; its result, if any, is registered in the result register.
// Throughput: one byte per cycle, limited only by backpressure on the result side.
// Reset (arst_n low, asynchronous): both stages empty, parser expects a tag byte.
module der_tlv_header_parser_unit (
	input  logic       clk,
	input  logic       arst_n,
	dtlv_byte_if.sink  byte_in,
	dtlv_hdr_if.source hdr_out
);
	import dtlv_pkg::*;

	// input stage
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	// parser state
	phase_t              phase_q;
	logic [BYTE_W-1:0]   held_tag_q;
	logic [LENGTH_W-1:0] accum_q;
	logic [LEFT_W-1:0]   left_q;
	logic [HDR_W-1:0]    seen_q;

	// result register
	logic        out_valid_q;
	hdr_result_t out_q;

	logic out_free;
	logic advance;

	phase_t              phase_d;
	logic [BYTE_W-1:0]   held_tag_d;
	logic [LENGTH_W-1:0] accum_d;
	logic [LEFT_W-1:0]   left_d;
	logic [HDR_W-1:0]    seen_d;
	logic                emit;
	hdr_result_t         res;
	logic [6:0]          cnt;
	logic [LEFT_W-1:0]   left_dec;

	assign out_free     = !out_valid_q || hdr_out.ready;
	assign advance      = valid_s1 && out_free;
	assign byte_in.ready = !valid_s1 || out_free;

	assign cnt      = byte_s1[6:0] & COUNT_MASK[6:0];
	assign left_dec = (left_q != '0) ? left_q - LEFT_W'(1) : left_q;

	always_comb begin
		phase_d    = phase_q;
		held_tag_d = held_tag_q;
		accum_d    = accum_q;
		left_d     = left_q;
		seen_d     = seen_q;
		emit       = 1'b0;
		res.tag_value    = held_tag_q;
		res.value_length = '0;
		res.header_bytes = HDR_TAG_LEN;
		res.status       = STATUS_OK;
		case (phase_q)
			PH_LEN: begin
				seen_d = HDR_TAG_LEN;
				if ((byte_s1 & LONG_FORM_BIT) == '0) begin
					accum_d          = LENGTH_W'(byte_s1);
					res.value_length = LENGTH_W'(byte_s1);
					emit             = 1'b1;
				end else begin
					accum_d = '0;
					if (32'(cnt) > 32'(MAX_LEN_BYTES)) begin
						res.status = STATUS_BAD_LEN;
						emit       = 1'b1;
					end else if (cnt == '0) begin
						emit = 1'b1;
					end else begin
						left_d  = LEFT_W'(cnt);
						phase_d = PH_MORE;
					end
				end
			end
			PH_MORE: begin
				accum_d = {accum_q[LENGTH_W-BYTE_W-1:0], byte_s1};
				seen_d  = seen_q + HDR_W'(1);
				left_d  = left_dec;
				if (left_dec == '0) begin
					res.value_length = {accum_q[LENGTH_W-BYTE_W-1:0], byte_s1};
					res.header_bytes = seen_q + HDR_W'(1);
					emit             = 1'b1;
				end
			end
			default: begin
				held_tag_d = byte_s1;
				seen_d     = HDR_TAG_ONLY;
				accum_d    = '0;
				left_d     = '0;
				phase_d    = PH_LEN;
			end
		endcase
		if (emit) begin
			phase_d = PH_TAG;
			left_d  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_in.ready) begin
			valid_s1 <= byte_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in.valid && byte_in.ready) begin
			byte_s1 <= byte_in.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_TAG;
			held_tag_q <= '0;
			accum_q    <= '0;
			left_q     <= '0;
			seen_q     <= '0;
		end else if (advance) begin
			phase_q    <= phase_d;
			held_tag_q <= held_tag_d;
			accum_q    <= accum_d;
			left_q     <= left_d;
			seen_q     <= seen_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_q <= res;
		end
	end

	assign hdr_out.valid        = out_valid_q;
	assign hdr_out.tag_value    = out_q.tag_value;
	assign hdr_out.value_length = out_q.value_length;
	assign hdr_out.header_bytes = out_q.header_bytes;
	assign hdr_out.status       = out_q.status;

endmodule
